// ----- hw/rtl/u8v_pkg.sv -----
// ----------------------------------------------------------------------------
// u8v_pkg
// Types and constants shared by the UTF-8 stream validator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package u8v_pkg;

   // Rule that applies to the second byte of a multi-byte sequence
   typedef enum logic [2:0] {
      RULE_ANY = 3'd0,
      RULE_E0  = 3'd1,
      RULE_ED  = 3'd2,
      RULE_F0  = 3'd3,
      RULE_F4  = 3'd4
   } rule_type;

   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] LEAD2_LO   = 8'hC2;
   localparam logic [7:0] LEAD2_HI   = 8'hDF;
   localparam logic [7:0] LEAD3_LO   = 8'hE0;
   localparam logic [7:0] LEAD3_HI   = 8'hEF;
   localparam logic [7:0] LEAD4_LO   = 8'hF0;
   localparam logic [7:0] LEAD4_HI   = 8'hF4;
   localparam logic [7:0] BYTE_E0    = 8'hE0;
   localparam logic [7:0] BYTE_ED    = 8'hED;
   localparam logic [7:0] BYTE_F0    = 8'hF0;
   localparam logic [7:0] BYTE_F4    = 8'hF4;
   localparam logic [7:0] BYTE_A0    = 8'hA0;
   localparam logic [7:0] BYTE_9F    = 8'h9F;
   localparam logic [7:0] BYTE_90    = 8'h90;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam int RESULT_WIDTH = 32;

   // One classified byte, handed from front to back
   typedef struct packed {
      logic       last;        // final byte of the string
      logic [1:0] lead_count;  // continuations a lead byte opens
      logic       bad_lead;    // byte can never start a sequence
      rule_type   rule;        // second-byte rule a lead byte opens
      logic       is_cont;     // 10xxxxxx
      logic       ge_a0;       // byte >= A0
      logic       le_9f;       // byte <= 9F
      logic       ge_90;       // byte >= 90
   } class_type;

endpackage

`default_nettype wire

// ----- hw/rtl/utf8_stream_validator_top.sv -----
// ----------------------------------------------------------------------------
// utf8_stream_validator_top
// Strict UTF-8 checker for a byte stream, one result per string.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Handshake              Payload
// req       in   req_tvalid/req_tready  req_tdata[7:0] byte, req_tlast final byte
// rsp       out  rsp_tvalid/rsp_tready  rsp_tuser[0] valid flag,
//                                       rsp_tdata[31:0] offset
//
// One byte per cycle while no result stall holds a final byte: the front
// registers a classification, a two-entry queue feeds the back, and the back
// updates sequence state per byte. The result is registered in the back after
// the final byte has passed the front register and the queue.
// Reset is synchronous and clears all control state; no clearing pass.
// A stalled result only blocks final bytes; the bytes before them drain on.
// Offsets count modulo 2^OFFSET_WIDTH; the result carries the low 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_validator_top import u8v_pkg::*; #(
   parameter int OFFSET_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // last_byte
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] invalid_offset
   output logic [0:0]       rsp_tuser    // [0] is_valid
);

   logic      front_valid;
   logic      front_ready;
   class_type front_item;

   logic      q_valid;
   logic      q_pop;
   class_type q_item;

   logic      res_ok;

   // classification stage
   u8v_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_last   (req_tlast),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_item  (front_item)
   );

   // decouples the front from result back-pressure
   u8v_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_item  (front_item),
      .pop_valid  (q_valid),
      .pop        (q_pop),
      .pop_item   (q_item)
   );

   // sequence tracking and result register
   u8v_back #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_pop     (q_pop),
      .in_item    (q_item),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_ok     (res_ok),
      .out_offset (rsp_tdata)
   );

   assign rsp_tuser = res_ok;

endmodule

`default_nettype wire

// ----- hw/rtl/u8v_front.sv -----
// ----------------------------------------------------------------------------
// u8v_front
// Accepts bytes and registers their classification for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module u8v_front import u8v_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire logic [7:0] in_byte,
   input  wire logic       in_last,
   output logic            out_valid,
   input  wire logic       out_ready,
   output class_type       out_item
);

   logic      valid_ff, valid_in;
   class_type item_ff, item_in;

   always_comb begin
      logic [7:0] b;
      b = in_byte;
      item_in            = '0;
      item_in.last       = in_last;
      item_in.rule       = RULE_ANY;
      item_in.is_cont    = (b & CONT_MASK) == CONT_CODE;
      item_in.ge_a0      = b >= BYTE_A0;
      item_in.le_9f      = b <= BYTE_9F;
      item_in.ge_90      = b >= BYTE_90;
      if (b < CONT_CODE) begin
         item_in.lead_count = 2'd0;
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
         item_in.lead_count = 2'd1;
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
         item_in.lead_count = 2'd2;
         if (b == BYTE_E0) item_in.rule = RULE_E0;
         else if (b == BYTE_ED) item_in.rule = RULE_ED;
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
         item_in.lead_count = 2'd3;
         if (b == BYTE_F0) item_in.rule = RULE_F0;
         else if (b == BYTE_F4) item_in.rule = RULE_F4;
      end else begin
         item_in.bad_lead = 1'b1;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/u8v_queue.sv -----
// ----------------------------------------------------------------------------
// u8v_queue
// Short FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module u8v_queue import u8v_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push_valid,
   output logic           push_ready,
   input  wire class_type push_item,
   output logic           pop_valid,
   input  wire logic      pop,
   output class_type      pop_item
);

   class_type               entries_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff, count_in;
   logic                    push;

   localparam logic [QCNT_WIDTH-1:0] DEPTH_CNT  = QCNT_WIDTH'(QUEUE_DEPTH);
   localparam logic [QPTR_WIDTH-1:0] LAST_SLOT  = QPTR_WIDTH'(QUEUE_DEPTH - 1);

   assign push_ready = count_ff != DEPTH_CNT;
   assign push       = push_valid && push_ready;
   assign pop_valid  = count_ff != '0;
   assign pop_item   = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("queue count beyond depth");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- hw/rtl/u8v_back.sv -----
// ----------------------------------------------------------------------------
// u8v_back
// Sequence tracking, offsets, and the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module u8v_back import u8v_pkg::*; #(
   parameter int OFFSET_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_pop,
   input  wire class_type   in_item,
   output logic             out_valid,
   input  wire logic        out_ready,
   output logic             out_ok,
   output logic [RESULT_WIDTH-1:0] out_offset
);

   logic [1:0]              pend_ff, pend_in;
   rule_type                rule_ff, rule_in;
   logic                    await_ff, await_in;
   logic [OFFSET_WIDTH-1:0] pos_ff, pos_in;
   logic [OFFSET_WIDTH-1:0] start_ff, start_in;
   logic                    err_ff, err_in;
   logic [OFFSET_WIDTH-1:0] errpos_ff, errpos_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff;
   logic [RESULT_WIDTH-1:0] rsp_ofs_ff;

   logic                    out_free;
   logic                    sec_ok;
   logic                    res_ok;
   logic [OFFSET_WIDTH-1:0] res_ofs;

   assign out_free = !rsp_valid_ff || out_ready;
   // non-final bytes never wait on the result register
   assign in_pop   = in_valid && (!in_item.last || out_free);

   always_comb begin
      case (rule_ff)
         RULE_E0: sec_ok = in_item.ge_a0;
         RULE_ED: sec_ok = in_item.le_9f;
         RULE_F0: sec_ok = in_item.ge_90;
         RULE_F4: sec_ok = !in_item.ge_90;
         default: sec_ok = 1'b1;
      endcase
   end

   always_comb begin
      logic trunc;
      pend_in   = pend_ff;
      rule_in   = rule_ff;
      await_in  = await_ff;
      pos_in    = pos_ff;
      start_in  = start_ff;
      err_in    = err_ff;
      errpos_in = errpos_ff;
      trunc     = 1'b0;
      res_ok    = 1'b0;
      res_ofs   = '0;
      if (in_pop) begin
         if (!err_ff) begin
            if (pend_ff == 2'd0) begin
               start_in = pos_ff;
               rule_in  = in_item.rule;
               pend_in  = in_item.lead_count;
               await_in = in_item.lead_count != 2'd0;
               if (in_item.bad_lead) begin
                  err_in    = 1'b1;
                  errpos_in = pos_ff;
               end
            end else if (!(in_item.is_cont && (!await_ff || sec_ok))) begin
               // bad continuation: report the sequence start
               err_in    = 1'b1;
               errpos_in = start_ff;
            end else begin
               pend_in  = pend_ff - 2'd1;
               await_in = 1'b0;
            end
         end
         pos_in = pos_ff + 1'b1;
         if (in_item.last) begin
            trunc   = !err_in && pend_in != 2'd0;
            res_ok  = !err_in && !trunc;
            res_ofs = err_in ? errpos_in : (trunc ? start_in : pos_in);
            pend_in   = 2'd0;
            rule_in   = RULE_ANY;
            await_in  = 1'b0;
            pos_in    = '0;
            start_in  = '0;
            err_in    = 1'b0;
            errpos_in = '0;
         end
      end
   end

   assign rsp_valid_in = (in_pop && in_item.last) ? 1'b1 :
                         (out_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 2'd0;
         rule_ff      <= RULE_ANY;
         await_ff     <= 1'b0;
         pos_ff       <= '0;
         start_ff     <= '0;
         err_ff       <= 1'b0;
         errpos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rule_ff      <= rule_in;
         await_ff     <= await_in;
         pos_ff       <= pos_in;
         start_ff     <= start_in;
         err_ff       <= err_in;
         errpos_ff    <= errpos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_pop && in_item.last) begin
         rsp_ok_ff  <= res_ok;
         rsp_ofs_ff <= RESULT_WIDTH'(res_ofs);
      end
   end

   assign out_valid  = rsp_valid_ff;
   assign out_ok     = rsp_ok_ff;
   assign out_offset = rsp_ofs_ff;

   a_await_needs_pend: assert property (@(posedge clock) disable iff (reset)
      await_ff |-> pend_ff != 2'd0)
      else $error("second-byte check armed with no pending continuation");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (in_pop && in_item.last) |=> (pos_ff == '0 && !err_ff && pend_ff == 2'd0))
      else $error("state not cleared after final byte");

endmodule

`default_nettype wire
